@@ rtl/core/lsi_pkg.sv @@
package lsi_pkg;

    // default coordinate width
    localparam int COORD_WIDTH = 16;

    // configuration register index
    localparam int REG_SEGMENT_MODE = 0;

    // result codes
    typedef enum logic [1:0] {
        ST_HIT       = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    // control that travels beside the payload
    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

    // stage count of one coordinate lane: multiply, setup, one per quotient bit, clamp
    function automatic int lane_lat(input int cw);
        return cw + 5;
    endfunction

endpackage

@@ rtl/core/line_segment_intersection_top.sv @@
// throughput: one word per cycle while the output skid is empty; depth is set
// by the restoring divider in each coordinate lane, one quotient bit per stage
// over COORD_WIDTH + 2 stages
// reset: rst_n clears all valid bits and the output skid, segment_mode returns to 1
module line_segment_intersection_top #(
    parameter int COORD_WIDTH = lsi_pkg::COORD_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // fields from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // fields from bit 0: status, point_x, point_y
    output logic [((2*COORD_WIDTH+9)/8)*8-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW     = COORD_WIDTH;
    localparam int NW     = 2 * CW + 3;
    localparam int LAT    = lsi_pkg::lane_lat(COORD_WIDTH);
    localparam int OUT_TW = ((2 * CW + 9) / 8) * 8;
    localparam int RES_W  = 2 + 2 * CW;

    // configuration port
    logic mode_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == 3'(4 * lsi_pkg::REG_SEGMENT_MODE)))
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == 3'(4 * lsi_pkg::REG_SEGMENT_MODE)) ? {31'b0, mode_reg} : '0;

    // pipeline advance, held while the skid is occupied
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // cross products and classification
    lsi_pkg::ctl_t        ctl_c;
    logic signed [CW-1:0] base_x, base_y;
    logic [CW:0]          mag_dx, mag_dy;
    logic [NW-1:0]        mag_n, mag_d;
    logic                 neg_x, neg_y;

    lsi_cross #(.CW(CW)) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .mode     (mode_reg),
        .ax1      (s_tdata[0*CW +: CW]),
        .ay1      (s_tdata[1*CW +: CW]),
        .ax2      (s_tdata[2*CW +: CW]),
        .ay2      (s_tdata[3*CW +: CW]),
        .bx1      (s_tdata[4*CW +: CW]),
        .by1      (s_tdata[5*CW +: CW]),
        .bx2      (s_tdata[6*CW +: CW]),
        .by2      (s_tdata[7*CW +: CW]),
        .ctl      (ctl_c),
        .base_x   (base_x),
        .base_y   (base_y),
        .mag_dx   (mag_dx),
        .mag_dy   (mag_dy),
        .mag_n    (mag_n),
        .mag_d    (mag_d),
        .neg_x    (neg_x),
        .neg_y    (neg_y)
    );

    // one divider lane per coordinate
    logic signed [CW-1:0] px, py;
    logic                 clx, cly;

    lsi_lane #(.CW(CW)) u_lane_x (
        .clk       (clk),
        .en        (en),
        .base      (base_x),
        .mag_delta (mag_dx),
        .mag_n     (mag_n),
        .mag_d     (mag_d),
        .neg       (neg_x),
        .coord     (px),
        .clamped   (clx)
    );

    lsi_lane #(.CW(CW)) u_lane_y (
        .clk       (clk),
        .en        (en),
        .base      (base_y),
        .mag_delta (mag_dy),
        .mag_n     (mag_n),
        .mag_d     (mag_d),
        .neg       (neg_y),
        .coord     (py),
        .clamped   (cly)
    );

    // control delay matching the lanes
    lsi_pkg::ctl_t ctl_pipe_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctl_pipe_reg[i] <= '{valid: 1'b0, status: lsi_pkg::ST_HIT};
            end
        end
        else if (en)
        begin
            ctl_pipe_reg[0] <= ctl_c;
            for (int i = 1; i < LAT; i++)
            begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
        end
    end

    // result word assembly
    lsi_pkg::ctl_t  last;
    lsi_pkg::status_t st_fin;
    logic [RES_W-1:0] res_next;

    always_comb
    begin
        last = ctl_pipe_reg[LAT-1];
        if (last.status == lsi_pkg::ST_HIT)
        begin
            st_fin   = (clx || cly) ? lsi_pkg::ST_SATURATED : lsi_pkg::ST_HIT;
            res_next = {py, px, st_fin};
        end
        else
        begin
            st_fin   = last.status;
            res_next = {{(2*CW){1'b0}}, st_fin};
        end
    end

    // output register with skid
    logic             out_valid_reg;
    logic [RES_W-1:0] out_reg, skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= last.valid;
        end
        else if (last.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_reg <= res_next;
        end
        else
        begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_reg);

    // skid only fills behind a waiting output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled while the output word was free to leave");

    // parallel and outside results carry a zero point
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == lsi_pkg::ST_PARALLEL
                      || m_tdata[1:0] == lsi_pkg::ST_OUTSIDE))
        |-> (m_tdata[RES_W-1:2] == '0))
        else $error("point not cleared for a miss");

endmodule

@@ rtl/core/lsi_cross.sv @@
module lsi_cross #(
    parameter int CW = lsi_pkg::COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  mode,
    input  logic signed [CW-1:0]  ax1,
    input  logic signed [CW-1:0]  ay1,
    input  logic signed [CW-1:0]  ax2,
    input  logic signed [CW-1:0]  ay2,
    input  logic signed [CW-1:0]  bx1,
    input  logic signed [CW-1:0]  by1,
    input  logic signed [CW-1:0]  bx2,
    input  logic signed [CW-1:0]  by2,
    output lsi_pkg::ctl_t         ctl,
    output logic signed [CW-1:0]  base_x,
    output logic signed [CW-1:0]  base_y,
    output logic [CW:0]           mag_dx,
    output logic [CW:0]           mag_dy,
    output logic [2*CW+2:0]       mag_n,
    output logic [2*CW+2:0]       mag_d,
    output logic                  neg_x,
    output logic                  neg_y
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;

    // stage a: differences
    logic                 va_reg;
    logic signed [DW-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, ox_reg, oy_reg;
    logic signed [CW-1:0] ax1_a_reg, ay1_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxa_reg   <= {ax2[CW-1], ax2} - {ax1[CW-1], ax1};
            dya_reg   <= {ay2[CW-1], ay2} - {ay1[CW-1], ay1};
            dxb_reg   <= {bx2[CW-1], bx2} - {bx1[CW-1], bx1};
            dyb_reg   <= {by2[CW-1], by2} - {by1[CW-1], by1};
            ox_reg    <= {ay1[CW-1], ay1} - {by1[CW-1], by1};
            oy_reg    <= {ax1[CW-1], ax1} - {bx1[CW-1], bx1};
            ax1_a_reg <= ax1;
            ay1_a_reg <= ay1;
        end
    end

    // stage b: six cross products
    logic                 vb_reg;
    logic signed [PW-1:0] p_d1_reg, p_d2_reg, p_a1_reg, p_a2_reg, p_b1_reg, p_b2_reg;
    logic signed [DW-1:0] dxa_b_reg, dya_b_reg;
    logic signed [CW-1:0] ax1_b_reg, ay1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_d1_reg  <= dyb_reg * dxa_reg;
            p_d2_reg  <= dxb_reg * dya_reg;
            p_a1_reg  <= dxb_reg * ox_reg;
            p_a2_reg  <= dyb_reg * oy_reg;
            p_b1_reg  <= dxa_reg * ox_reg;
            p_b2_reg  <= dya_reg * oy_reg;
            dxa_b_reg <= dxa_reg;
            dya_b_reg <= dya_reg;
            ax1_b_reg <= ax1_a_reg;
            ay1_b_reg <= ay1_a_reg;
        end
    end

    // stage c: denominator and both numerators
    logic                 vc_reg;
    logic signed [NW-1:0] d_reg, na_reg, nb_reg;
    logic signed [DW-1:0] dxa_c_reg, dya_c_reg;
    logic signed [CW-1:0] ax1_c_reg, ay1_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= {p_d1_reg[PW-1], p_d1_reg} - {p_d2_reg[PW-1], p_d2_reg};
            na_reg    <= {p_a1_reg[PW-1], p_a1_reg} - {p_a2_reg[PW-1], p_a2_reg};
            nb_reg    <= {p_b1_reg[PW-1], p_b1_reg} - {p_b2_reg[PW-1], p_b2_reg};
            dxa_c_reg <= dxa_b_reg;
            dya_c_reg <= dya_b_reg;
            ax1_c_reg <= ax1_b_reg;
            ay1_c_reg <= ay1_b_reg;
        end
    end

    // stage d: classification, magnitudes and signs
    logic [NW-1:0]  mn_next, mb_next, md_next;
    logic [DW-1:0]  mdx_next, mdy_next;
    logic           in_a, in_b;
    lsi_pkg::ctl_t  ctl_next;

    always_comb
    begin
        mn_next  = na_reg[NW-1] ? NW'(-na_reg) : NW'(na_reg);
        mb_next  = nb_reg[NW-1] ? NW'(-nb_reg) : NW'(nb_reg);
        md_next  = d_reg[NW-1] ? NW'(-d_reg) : NW'(d_reg);
        mdx_next = dxa_c_reg[DW-1] ? DW'(-dxa_c_reg) : DW'(dxa_c_reg);
        mdy_next = dya_c_reg[DW-1] ? DW'(-dya_c_reg) : DW'(dya_c_reg);
        in_a = ((na_reg == '0) || (na_reg[NW-1] == d_reg[NW-1])) && (mn_next <= md_next);
        in_b = ((nb_reg == '0) || (nb_reg[NW-1] == d_reg[NW-1])) && (mb_next <= md_next);
        ctl_next.valid = vc_reg;
        if (d_reg == '0)
        begin
            ctl_next.status = lsi_pkg::ST_PARALLEL;
        end
        else if (mode && !(in_a && in_b))
        begin
            ctl_next.status = lsi_pkg::ST_OUTSIDE;
        end
        else
        begin
            ctl_next.status = lsi_pkg::ST_HIT;
        end
    end

    lsi_pkg::ctl_t ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, status: lsi_pkg::ST_HIT};
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_x <= ax1_c_reg;
            base_y <= ay1_c_reg;
            mag_dx <= mdx_next;
            mag_dy <= mdy_next;
            mag_n  <= mn_next;
            mag_d  <= md_next;
            neg_x  <= na_reg[NW-1] ^ dxa_c_reg[DW-1] ^ d_reg[NW-1];
            neg_y  <= na_reg[NW-1] ^ dya_c_reg[DW-1] ^ d_reg[NW-1];
        end
    end

    assign ctl = ctl_reg;

endmodule

@@ rtl/core/lsi_lane.sv @@
module lsi_lane #(
    parameter int CW = lsi_pkg::COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CW-1:0]  base,
    input  logic [CW:0]           mag_delta,
    input  logic [2*CW+2:0]       mag_n,
    input  logic [2*CW+2:0]       mag_d,
    input  logic                  neg,
    output logic signed [CW-1:0]  coord,
    output logic                  clamped
);

    localparam int DW  = CW + 1;
    localparam int NW  = 2 * DW + 1;
    localparam int QB  = CW + 2;
    localparam int PRW = NW + DW;
    localparam int RW  = PRW + 2;
    localparam int VW  = CW + 4;

    // multiply |na| by |delta|
    logic [PRW-1:0]       prod_reg;
    logic [NW-1:0]        dm_reg;
    logic signed [CW-1:0] base_m_reg;
    logic                 neg_m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= PRW'(mag_n) * PRW'(mag_delta);
            dm_reg     <= mag_d;
            base_m_reg <= base;
            neg_m_reg  <= neg;
        end
    end

    // rounding bias and overflow test: q = floor((2p + d) / 2d)
    logic [RW-1:0] r0_next;
    logic          ovf0_next;

    always_comb
    begin
        r0_next   = RW'({prod_reg, 1'b0}) + RW'(dm_reg);
        ovf0_next = r0_next[RW-1:QB] >= {dm_reg, 1'b0};
    end

    logic [RW-1:0]        r_reg    [0:QB];
    logic [QB-1:0]        q_reg    [0:QB];
    logic [NW:0]          div_reg  [0:QB];
    logic signed [CW-1:0] base_reg [0:QB];
    logic                 neg_reg  [0:QB];
    logic                 ovf_reg  [0:QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= r0_next;
            q_reg[0]    <= '0;
            div_reg[0]  <= {dm_reg, 1'b0};
            base_reg[0] <= base_m_reg;
            neg_reg[0]  <= neg_m_reg;
            ovf_reg[0]  <= ovf0_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int BIT = QB - 1 - k;
        logic [RW-1:0] sh;
        logic          ge;

        always_comb
        begin
            sh = RW'(div_reg[k]) << BIT;
            ge = r_reg[k] >= sh;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]    <= ge ? r_reg[k] - sh : r_reg[k];
                q_reg[k+1]    <= q_reg[k] | (QB'(ge) << BIT);
                div_reg[k+1]  <= div_reg[k];
                base_reg[k+1] <= base_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    // apply offset and clamp to the coordinate range
    localparam logic signed [VW-1:0] LIM_HI = VW'((1 <<< (CW - 1)) - 1);
    localparam logic signed [VW-1:0] LIM_LO = -VW'(1 <<< (CW - 1));

    logic signed [VW-1:0] v_next;
    logic signed [CW-1:0] coord_next;
    logic                 clamp_next;

    always_comb
    begin
        v_next = neg_reg[QB]
               ? VW'(base_reg[QB]) - $signed(VW'(q_reg[QB]))
               : VW'(base_reg[QB]) + $signed(VW'(q_reg[QB]));
        if (ovf_reg[QB])
        begin
            clamp_next = 1'b1;
            coord_next = neg_reg[QB] ? LIM_LO[CW-1:0] : LIM_HI[CW-1:0];
        end
        else if (v_next > LIM_HI)
        begin
            clamp_next = 1'b1;
            coord_next = LIM_HI[CW-1:0];
        end
        else if (v_next < LIM_LO)
        begin
            clamp_next = 1'b1;
            coord_next = LIM_LO[CW-1:0];
        end
        else
        begin
            clamp_next = 1'b0;
            coord_next = v_next[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coord   <= coord_next;
            clamped <= clamp_next;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CW         = 16;
    localparam int LATENCY    = 26;
    localparam int DRAIN      = 2 * LATENCY + 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int PHASE_LEN  = 330;
    localparam longint QCAP   = 64'd1 << 40;

    // one pair of segments, first field in the lowest bits
    typedef struct packed {
        logic signed [CW-1:0] b_end_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_start_x;
    } seg_pair_t;

    typedef struct {
        lsi_pkg::status_t     status;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } crossing_t;

    typedef struct {
        seg_pair_t pair;
        logic      mode;
        logic      typed;
        crossing_t want;
    } vector_t;

    logic         clk;
    logic         rst_n;
    logic [127:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    crossing_t    crossing_q[$];
    logic         mode_now;
    int           err_count;
    int           cycles;
    logic         rx_no_stall;
    logic         tx_no_gap;
    vector_t      vectors[$];

    line_segment_intersection_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic in_unit(input longint n, input longint d);
        return (n == 0 || ((n < 0) == (d < 0))) && (magnitude(n) <= magnitude(d));
    endfunction

    // one coordinate: base + na*delta/d rounded to nearest, ties away from zero
    function automatic longint lane_point(input longint base, input longint delta,
                                          input longint na, input longint d,
                                          inout logic clamped);
        logic [127:0] prod;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        longint       q;
        longint       v;
        logic         neg;
        prod = {64'd0, magnitude(na)} * {64'd0, magnitude(delta)};
        den  = {64'd0, magnitude(d)};
        quo  = prod / den;
        rem  = prod % den;
        if ((rem << 1) >= den)
            quo = quo + 1;
        if (quo > QCAP)
            quo = QCAP;
        q   = quo[63:0];
        neg = ((na < 0) != (delta < 0)) != (d < 0);
        v   = neg ? base - q : base + q;
        if (v > 32767)
        begin
            clamped = 1'b1;
            v = 32767;
        end
        else if (v < -32768)
        begin
            clamped = 1'b1;
            v = -32768;
        end
        return v;
    endfunction

    // expected result of one pair under the given mode
    function automatic crossing_t predict_crossing(input seg_pair_t p, input logic mode);
        crossing_t r;
        longint    ax1, ay1, dxa, dya, dxb, dyb, ox, oy, d, na, nb;
        logic      clamped;
        ax1 = p.a_start_x;
        ay1 = p.a_start_y;
        dxa = longint'(p.a_end_x) - ax1;
        dya = longint'(p.a_end_y) - ay1;
        dxb = longint'(p.b_end_x) - longint'(p.b_start_x);
        dyb = longint'(p.b_end_y) - longint'(p.b_start_y);
        ox  = ay1 - longint'(p.b_start_y);
        oy  = ax1 - longint'(p.b_start_x);
        d   = dyb * dxa - dxb * dya;
        na  = dxb * ox - dyb * oy;
        nb  = dxa * ox - dya * oy;
        clamped = 1'b0;
        r.px = '0;
        r.py = '0;
        if (d == 0)
            r.status = lsi_pkg::ST_PARALLEL;
        else if (mode && !(in_unit(na, d) && in_unit(nb, d)))
            r.status = lsi_pkg::ST_OUTSIDE;
        else
        begin
            r.px = CW'(lane_point(ax1, dxa, na, d, clamped));
            r.py = CW'(lane_point(ay1, dya, na, d, clamped));
            r.status = clamped ? lsi_pkg::ST_SATURATED : lsi_pkg::ST_HIT;
        end
        return r;
    endfunction

    function automatic seg_pair_t mk_pair(input int ax1, input int ay1, input int ax2,
                                          input int ay2, input int bx1, input int by1,
                                          input int bx2, input int by2);
        seg_pair_t p;
        p.a_start_x = CW'(ax1);  p.a_start_y = CW'(ay1);
        p.a_end_x   = CW'(ax2);  p.a_end_y   = CW'(ay2);
        p.b_start_x = CW'(bx1);  p.b_start_y = CW'(by1);
        p.b_end_x   = CW'(bx2);  p.b_end_y   = CW'(by2);
        return p;
    endfunction

    function automatic int srand(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // random pair, mostly shaped so that segments meet or come close
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        kind, cx, cy, ux, uy, vx, vy, k1, k2, m;
        kind = $urandom_range(0, 99);
        cx = srand(20000);
        cy = srand(20000);
        if (kind < 15)
            p = {$urandom, $urandom, $urandom, $urandom};
        else if (kind < 45)
            p = mk_pair(cx + srand(20), cy + srand(20), cx + srand(20), cy + srand(20),
                        cx + srand(20), cy + srand(20), cx + srand(20), cy + srand(20));
        else if (kind < 75)
        begin
            ux = srand(100); uy = srand(100); vx = srand(100); vy = srand(100);
            k1 = $urandom_range(0, 3); k2 = $urandom_range(0, 3);
            p = mk_pair(cx - ux * k1, cy - uy * k1, cx + ux * k2, cy + uy * k2,
                        cx - vx * k2, cy - vy * k2, cx + vx * k1, cy + vy * k1);
        end
        else if (kind < 88)
        begin
            ux = srand(200); uy = srand(200); m = srand(3);
            vx = cx + srand(50); vy = cy + srand(50);
            p = mk_pair(cx, cy, cx + ux, cy + uy, vx, vy, vx + m * ux, vy + m * uy);
        end
        else
        begin
            ux = cx + srand(300); uy = cy + srand(300);
            p = mk_pair(cx, cy, ux, uy, ux, uy, ux + srand(300), uy + srand(300));
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    // apb write of the mode register
    task automatic write_mode(input logic mode);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(lsi_pkg::REG_SEGMENT_MODE * 4);
        pwdata  <= {31'd0, mode};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_now = mode;
    endtask

    // let the pipe empty before touching the register
    task automatic drain_pipe();
        while (crossing_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // push one word, prediction made at acceptance
    task automatic send_pair(input seg_pair_t p, input logic typed, input crossing_t want);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge clk); while (!s_tready);
        if (typed)
            crossing_q.push_back(want);
        else
            crossing_q.push_back(predict_crossing(p, mode_now));
        @(negedge clk);
    endtask

    // receiver back-pressure
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = rx_no_stall ? 0 : $urandom_range(0, 9);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        crossing_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (crossing_q.size() == 0)
            begin
                $display("unexpected result word at cycle %0d", cycles);
                err_count++;
            end
            else
            begin
                w = crossing_q.pop_front();
                if (m_tdata[1:0] !== w.status)
                    report_mismatch("status", m_tdata[1:0], w.status);
                if ($signed(m_tdata[17:2]) !== w.px)
                    report_mismatch("point_x", $signed(m_tdata[17:2]), w.px);
                if ($signed(m_tdata[33:18]) !== w.py)
                    report_mismatch("point_y", $signed(m_tdata[33:18]), w.py);
            end
        end
    end

    function automatic vector_t row(input logic mode, input seg_pair_t p, input logic typed,
                                    input lsi_pkg::status_t st, input int px, input int py);
        vector_t v;
        v.pair = p;
        v.mode = mode;
        v.typed = typed;
        v.want.status = st;
        v.want.px = CW'(px);
        v.want.py = CW'(py);
        return v;
    endfunction

    // main sequence
    initial
    begin
        err_count   = 0;
        rst_n       = 1'b0;
        s_tdata     = '0;
        s_tvalid    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mode_now    = 1'b1;
        rx_no_stall = 1'b0;
        tx_no_gap   = 1'b0;

        // directed vectors, segment mode rows first
        vectors.push_back(row(1, mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1,
                              lsi_pkg::ST_PARALLEL, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, 10, 10, 0, 10, 10, 0), 1,
                              lsi_pkg::ST_HIT, 5, 5));
        vectors.push_back(row(1, mk_pair(-32768, -32768, 32767, 32767,
                                         -32768, 32767, 32767, -32768), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(1, mk_pair(32767, 32767, 32767, 32767,
                                         32767, 32767, 32767, 32767), 1,
                              lsi_pkg::ST_PARALLEL, 0, 0));
        vectors.push_back(row(1, mk_pair(-32768, -32768, -32768, -32768,
                                         -32768, -32768, -32768, -32768),
                              1, lsi_pkg::ST_PARALLEL, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, 4, 0, 4, 0, 4, 5), 0, lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, 1, 1, 10, 0, 11, -1), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, 5, 0, 2, 0, 8, 0), 1,
                              lsi_pkg::ST_PARALLEL, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, 1, 1, 0, 1, 1, 0), 0, lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(1, mk_pair(0, 0, -1, -1, 0, -1, -1, 0), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(1, mk_pair(32767, -32768, -32768, 32767,
                                         -32768, -32768, 32767, 32767), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        // infinite line rows
        vectors.push_back(row(0, mk_pair(0, 0, 1, 1, 10, 0, 11, -1), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(0, mk_pair(32000, 0, 32001, 1, 0, 1000, 1, 1000),
                              1, lsi_pkg::ST_SATURATED, 32767, 1000));
        vectors.push_back(row(0, mk_pair(-32000, 0, -32001, 1, 0, 1000, 1, 1000),
                              1, lsi_pkg::ST_SATURATED, -32768, 1000));
        vectors.push_back(row(0, mk_pair(-32768, -32768, 32767, 32767,
                                         -32768, -32767, 32767, 32767), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(0, mk_pair(-32768, 32767, 32767, -32768,
                                         -32767, 32767, 32767, -32767), 0,
                              lsi_pkg::ST_HIT, 0, 0));
        vectors.push_back(row(0, mk_pair(1, 2, 3, 4, 5, 6, 7, 8), 1,
                              lsi_pkg::ST_PARALLEL, 0, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed walk
        foreach (vectors[i])
        begin
            if (vectors[i].mode != mode_now)
            begin
                s_tvalid <= 1'b0;
                drain_pipe();
                write_mode(vectors[i].mode);
            end
            send_pair(vectors[i].pair, vectors[i].typed, vectors[i].want);
        end
        s_tvalid <= 1'b0;

        // random phases alternating the mode
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_pipe();
            write_mode(ph[0] ? 1'b1 : 1'b0);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (i % 60 == 0)
                begin
                    tx_no_gap   = ($urandom_range(0, 3) == 0);
                    rx_no_stall = ($urandom_range(0, 3) == 0);
                end
                send_pair(random_pair(), 1'b0, '{lsi_pkg::ST_HIT, 0, 0});
            end
            s_tvalid <= 1'b0;
        end

        // wind down
        while (crossing_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
